@@ rtl/cosine_similarity_stream_assert.svh @@
// ============================================================================
// Assertion macros for the cosine similarity stream
// Shared forms for the concurrent checks on the block's ports.
// ============================================================================
`ifndef COSINE_SIMILARITY_STREAM_ASSERT_SVH
`define COSINE_SIMILARITY_STREAM_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define CSIM_ASSERT_SAME(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("cosine similarity check failed");

// The consequent must hold in the cycle after the antecedent.
`define CSIM_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("cosine similarity check failed");

`endif

@@ rtl/csim_pkg.sv @@
// ============================================================================
// csim_pkg
// Types and constants shared by the cosine similarity stream modules.
// ============================================================================
package csim_pkg;

    // Element and accumulator widths.
    localparam int ElemW   = 16;
    localparam int AccW    = 48;
    localparam int ProdW   = 2 * AccW;
    // The quotient only matters up to 2^30 (the square of full scale).
    localparam int QuoW    = 31;
    localparam int RootW   = 16;
    localparam int SimW    = 16;

    // Iteration counts of the serial units.
    localparam int MulSteps  = AccW;
    localparam int DivSteps  = ProdW + 30;
    localparam int SqrtSteps = RootW;
    localparam int CntW      = $clog2(DivSteps);

    // Controller states.
    typedef enum logic [3:0] {
        ST_ACCUM,
        ST_LOAD_P,
        ST_MUL_P,
        ST_LOAD_S,
        ST_MUL_S,
        ST_LOAD_DIV,
        ST_DIV,
        ST_LOAD_SQRT,
        ST_SQRT,
        ST_EMIT
    } state_t;

    // Multiplier operand select.
    typedef enum logic {
        MUL_ENERGY,
        MUL_DOT
    } mul_sel_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic     acc_en;
        logic     mul_load;
        mul_sel_t mul_sel;
        logic     mul_step;
        logic     div_load;
        logic     div_step;
        logic     sqrt_load;
        logic     sqrt_step;
        logic     out_load;
    } cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic out_free;
    } status_t;

endpackage

@@ rtl/csim_if.sv @@
// ============================================================================
// csim_in_if / csim_out_if
// Valid/ready channels carrying element pairs in and similarity results out.
// ============================================================================
interface csim_in_if;
    logic                               valid;
    logic                               ready;
    logic signed [csim_pkg::ElemW-1:0]  elem_a;
    logic signed [csim_pkg::ElemW-1:0]  elem_b;
    logic                               is_last;

    modport source (output valid, output elem_a, output elem_b, output is_last,
                    input ready);
    modport sink   (input valid, input elem_a, input elem_b, input is_last,
                    output ready);
endinterface

interface csim_out_if;
    logic                              valid;
    logic                              ready;
    logic signed [csim_pkg::SimW-1:0]  similarity;
    logic                              zero_norm;

    modport source (output valid, output similarity, output zero_norm, input ready);
    modport sink   (input valid, input similarity, input zero_norm, output ready);
endinterface

@@ rtl/csim_ctrl.sv @@
// ============================================================================
// csim_ctrl
// Sequencer that steps the datapath through accumulation and the final
// multiply, divide and square root.
// ============================================================================
module csim_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    input  logic               in_is_last,
    output logic               in_ready,
    output csim_pkg::cmd_t     cmd,
    input  csim_pkg::status_t  status
);

    csim_pkg::state_t              state_reg, state_next;
    logic [csim_pkg::CntW-1:0]     cnt_reg, cnt_next;

    // State and iteration counter.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= csim_pkg::ST_ACCUM;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    // Next state and commands.
    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        in_ready   = 1'b0;
        cmd        = '0;
        unique case (state_reg)
            csim_pkg::ST_ACCUM:
            begin
                in_ready   = 1'b1;
                cmd.acc_en = in_valid;
                if (in_valid && in_is_last)
                begin
                    state_next = csim_pkg::ST_LOAD_P;
                end
            end
            csim_pkg::ST_LOAD_P:
            begin
                cmd.mul_load = 1'b1;
                cmd.mul_sel  = csim_pkg::MUL_ENERGY;
                cnt_next     = '0;
                state_next   = csim_pkg::ST_MUL_P;
            end
            csim_pkg::ST_MUL_P:
            begin
                cmd.mul_step = 1'b1;
                cnt_next     = cnt_reg + 1'b1;
                if (cnt_reg == csim_pkg::CntW'(csim_pkg::MulSteps - 1))
                begin
                    state_next = csim_pkg::ST_LOAD_S;
                end
            end
            csim_pkg::ST_LOAD_S:
            begin
                cmd.mul_load = 1'b1;
                cmd.mul_sel  = csim_pkg::MUL_DOT;
                cnt_next     = '0;
                state_next   = csim_pkg::ST_MUL_S;
            end
            csim_pkg::ST_MUL_S:
            begin
                cmd.mul_step = 1'b1;
                cnt_next     = cnt_reg + 1'b1;
                if (cnt_reg == csim_pkg::CntW'(csim_pkg::MulSteps - 1))
                begin
                    state_next = csim_pkg::ST_LOAD_DIV;
                end
            end
            csim_pkg::ST_LOAD_DIV:
            begin
                cmd.div_load = 1'b1;
                cnt_next     = '0;
                state_next   = csim_pkg::ST_DIV;
            end
            csim_pkg::ST_DIV:
            begin
                cmd.div_step = 1'b1;
                cnt_next     = cnt_reg + 1'b1;
                if (cnt_reg == csim_pkg::CntW'(csim_pkg::DivSteps - 1))
                begin
                    state_next = csim_pkg::ST_LOAD_SQRT;
                end
            end
            csim_pkg::ST_LOAD_SQRT:
            begin
                cmd.sqrt_load = 1'b1;
                cnt_next      = '0;
                state_next    = csim_pkg::ST_SQRT;
            end
            csim_pkg::ST_SQRT:
            begin
                cmd.sqrt_step = 1'b1;
                cnt_next      = cnt_reg + 1'b1;
                if (cnt_reg == csim_pkg::CntW'(csim_pkg::SqrtSteps - 1))
                begin
                    state_next = csim_pkg::ST_EMIT;
                end
            end
            csim_pkg::ST_EMIT:
            begin
                if (status.out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = csim_pkg::ST_ACCUM;
                end
            end
            default:
            begin
                state_next = csim_pkg::ST_ACCUM;
            end
        endcase
    end

endmodule

@@ rtl/csim_dp.sv @@
// ============================================================================
// csim_dp
// Accumulators, shift-add multiplier, restoring divider, bit-serial square
// root and the output register.
// ============================================================================
module csim_dp (
    input  logic                               clk,
    input  logic                               rst_n,
    input  csim_pkg::cmd_t                     cmd,
    output csim_pkg::status_t                  status,
    input  logic signed [csim_pkg::ElemW-1:0]  elem_a,
    input  logic signed [csim_pkg::ElemW-1:0]  elem_b,
    output logic                               out_valid,
    input  logic                               out_ready,
    output logic signed [csim_pkg::SimW-1:0]   similarity,
    output logic                               zero_norm
);

    localparam int PW = 2 * csim_pkg::ElemW;
    localparam int XW = csim_pkg::AccW - PW;

    // Running sums.
    logic [csim_pkg::AccW-1:0]   dot_reg, ea_reg, eb_reg;
    // Shift-add multiplier.
    logic [csim_pkg::ProdW-1:0]  mcand_reg, macc_reg, energy_prod_reg;
    logic [csim_pkg::AccW-1:0]   mplier_reg;
    // Restoring divider.
    logic [csim_pkg::ProdW-1:0]  rem_reg, dvd_reg;
    logic [csim_pkg::QuoW-1:0]   quo_reg;
    logic                        quo_sat_reg;
    // Square root.
    logic [csim_pkg::QuoW-1:0]   rad_reg;
    logic [csim_pkg::RootW-1:0]  root_reg, rbit_reg;
    // Output register.
    logic                        out_valid_reg;
    logic signed [csim_pkg::SimW-1:0] sim_reg;
    logic                        zero_reg;

    logic signed [PW-1:0]        p_ab, p_aa, p_bb;
    logic [csim_pkg::AccW-1:0]   dot_mag;
    logic                        dot_neg;
    logic [csim_pkg::ProdW:0]    rem_sh;
    logic                        qbit;
    logic [csim_pkg::RootW-1:0]  root_try;
    logic [2*csim_pkg::RootW-1:0] root_sq;
    logic [csim_pkg::RootW-1:0]  mag_q;
    logic                        is_zero;
    logic signed [csim_pkg::SimW-1:0] sim_val;

    // Element products.
    assign p_ab = elem_a * elem_b;
    assign p_aa = elem_a * elem_a;
    assign p_bb = elem_b * elem_b;

    // Sign and magnitude of the dot product.
    assign dot_neg = dot_reg[csim_pkg::AccW-1];
    assign dot_mag = dot_neg ? (csim_pkg::AccW'(0) - dot_reg) : dot_reg;

    // Divider trial subtraction.
    assign rem_sh = {rem_reg, dvd_reg[csim_pkg::ProdW-1]};
    assign qbit   = (rem_sh >= {1'b0, energy_prod_reg});

    // Square root trial bit.
    assign root_try = root_reg | rbit_reg;
    assign root_sq  = root_try * root_try;

    // Result formatting: magnitude is limited to full scale.
    assign mag_q   = (root_reg > csim_pkg::RootW'(32768)) ? csim_pkg::RootW'(32768)
                                                          : root_reg;
    assign is_zero = (ea_reg == '0) || (eb_reg == '0);
    always_comb
    begin
        if (is_zero)
        begin
            sim_val = '0;
        end
        else if (dot_neg)
        begin
            sim_val = csim_pkg::SimW'(0) - mag_q;
        end
        else if (mag_q > csim_pkg::RootW'(32767))
        begin
            sim_val = csim_pkg::SimW'(32767);
        end
        else
        begin
            sim_val = mag_q;
        end
    end

    // Accumulators; cleared once the result is loaded.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dot_reg <= '0;
            ea_reg  <= '0;
            eb_reg  <= '0;
        end
        else if (cmd.out_load)
        begin
            dot_reg <= '0;
            ea_reg  <= '0;
            eb_reg  <= '0;
        end
        else if (cmd.acc_en)
        begin
            dot_reg <= dot_reg + {{XW{p_ab[PW-1]}}, p_ab};
            ea_reg  <= ea_reg + {{XW{p_aa[PW-1]}}, p_aa};
            eb_reg  <= eb_reg + {{XW{p_bb[PW-1]}}, p_bb};
        end
    end

    // Serial arithmetic units.
    always_ff @(posedge clk)
    begin
        if (cmd.mul_load)
        begin
            macc_reg <= '0;
            if (cmd.mul_sel == csim_pkg::MUL_DOT)
            begin
                energy_prod_reg <= macc_reg;
                mcand_reg       <= {{csim_pkg::AccW{1'b0}}, dot_mag};
                mplier_reg      <= dot_mag;
            end
            else
            begin
                mcand_reg  <= {{csim_pkg::AccW{1'b0}}, ea_reg};
                mplier_reg <= eb_reg;
            end
        end
        else if (cmd.mul_step)
        begin
            if (mplier_reg[0])
            begin
                macc_reg <= macc_reg + mcand_reg;
            end
            mcand_reg  <= {mcand_reg[csim_pkg::ProdW-2:0], 1'b0};
            mplier_reg <= {1'b0, mplier_reg[csim_pkg::AccW-1:1]};
        end

        if (cmd.div_load)
        begin
            rem_reg     <= '0;
            dvd_reg     <= macc_reg;
            quo_reg     <= '0;
            quo_sat_reg <= 1'b0;
        end
        else if (cmd.div_step)
        begin
            rem_reg     <= qbit ? csim_pkg::ProdW'(rem_sh - {1'b0, energy_prod_reg})
                                : csim_pkg::ProdW'(rem_sh);
            dvd_reg     <= {dvd_reg[csim_pkg::ProdW-2:0], 1'b0};
            quo_reg     <= {quo_reg[csim_pkg::QuoW-2:0], qbit};
            quo_sat_reg <= quo_sat_reg | quo_reg[csim_pkg::QuoW-1];
        end

        if (cmd.sqrt_load)
        begin
            rad_reg  <= quo_sat_reg ? csim_pkg::QuoW'(1 << 30) : quo_reg;
            root_reg <= '0;
            rbit_reg <= {1'b1, {(csim_pkg::RootW-1){1'b0}}};
        end
        else if (cmd.sqrt_step)
        begin
            if (root_sq <= {1'b0, rad_reg})
            begin
                root_reg <= root_try;
            end
            rbit_reg <= {1'b0, rbit_reg[csim_pkg::RootW-1:1]};
        end

        if (cmd.out_load)
        begin
            sim_reg  <= sim_val;
            zero_reg <= is_zero;
        end
    end

    // Output valid flag.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    assign status.out_free = !out_valid_reg || out_ready;
    assign out_valid       = out_valid_reg;
    assign similarity      = sim_reg;
    assign zero_norm       = zero_reg;

endmodule

@@ rtl/cosine_similarity_stream.sv @@
// ============================================================================
// cosine_similarity_stream
// Streaming cosine similarity of two fixed-point vectors, result in Q1.15.
// ============================================================================
//
//  Channel     Direction  Payload
//  in_stream   sink       elem_a, elem_b, is_last
//  out_stream  source     similarity, zero_norm
//
// Element pairs are taken one per cycle while the block accumulates.
// After the pair marked last, input is held off through two 48-step
// shift-add multiplies, a 126-step restoring divide and a 16-step square
// root, each after a load state, and the load of the output register.
// The result is offered in the cycle after; a waiting result holds the load,
// and input, until it transfers. Reset clears the FSM, sums and out_valid.
module cosine_similarity_stream (
    input  logic        clk,
    input  logic        rst_n,
    csim_in_if.sink     in_stream,
    csim_out_if.source  out_stream
);

    csim_pkg::cmd_t     cmd;
    csim_pkg::status_t  status;

    // Sequencer.
    csim_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_stream.valid),
        .in_is_last (in_stream.is_last),
        .in_ready   (in_stream.ready),
        .cmd        (cmd),
        .status     (status)
    );

    // Arithmetic and output register.
    csim_dp u_dp (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .status     (status),
        .elem_a     (in_stream.elem_a),
        .elem_b     (in_stream.elem_b),
        .out_valid  (out_stream.valid),
        .out_ready  (out_stream.ready),
        .similarity (out_stream.similarity),
        .zero_norm  (out_stream.zero_norm)
    );

endmodule

@@ rtl/csim_checker.sv @@
// ============================================================================
// csim_checker
// Port-level checks on the cosine similarity stream, bound to the top level.
// ============================================================================
`include "cosine_similarity_stream_assert.svh"

module csim_checker (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               in_valid,
    input  logic                               in_ready,
    input  logic                               in_is_last,
    input  logic                               out_valid,
    input  logic                               out_ready,
    input  logic signed [csim_pkg::SimW-1:0]   similarity,
    input  logic                               zero_norm
);

    // A stalled result keeps its value.
    `CSIM_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(similarity))
    // A zero-norm result always reads as zero.
    `CSIM_ASSERT_SAME(a_zero_sim, clk, rst_n, out_valid && zero_norm, similarity == '0)
    // Input is held off while the final arithmetic runs.
    `CSIM_ASSERT_NEXT(a_last_stall, clk, rst_n, in_valid && in_ready && in_is_last, !in_ready)
    // No result can appear right after the last pair.
    `CSIM_ASSERT_NEXT(a_no_fast_out, clk, rst_n, in_valid && in_ready && in_is_last, !$rose(out_valid))

endmodule

bind cosine_similarity_stream csim_checker u_csim_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_stream.valid),
    .in_ready   (in_stream.ready),
    .in_is_last (in_stream.is_last),
    .out_valid  (out_stream.valid),
    .out_ready  (out_stream.ready),
    .similarity (out_stream.similarity),
    .zero_norm  (out_stream.zero_norm)
);

@@ tb/tb.sv @@
// ============================================================================
// Cosine similarity stream testbench
// Streams element pairs into the block, predicts each Q1.15 similarity from
// its own copy of the running sums and compares every result transfer.
// ============================================================================
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int  CycleLimit  = 3_000_000;
    localparam int  DrainCycles = 300;
    localparam int  RandomItems = 930;
    localparam int  LongLength  = 100;

    typedef struct packed {
        logic signed [csim_pkg::SimW-1:0] similarity;
        logic                             zero_norm;
    } sim_result_t;

    logic clk;
    logic rst_n;

    csim_in_if  in_ch ();
    csim_out_if out_ch ();

    cosine_similarity_stream dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_stream  (in_ch),
        .out_stream (out_ch)
    );

    // Running sums of the predictor, mirroring the block's accumulators.
    logic [csim_pkg::AccW-1:0] dot_acc;
    logic [csim_pkg::AccW-1:0] energy_acc_a;
    logic [csim_pkg::AccW-1:0] energy_acc_b;

    sim_result_t pending_results[$];
    int unsigned mismatches;
    int unsigned results_seen;
    int unsigned vectors_sent;
    int unsigned pairs_sent;
    int unsigned zero_norm_seen;
    int unsigned cycle_count;
    bit          idle_enable;
    bit          stall_enable;

    // Clock generation.
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Cycle counter with a hard limit on the run length.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CycleLimit)
        begin
            $display("Timeout after %0d cycles", cycle_count);
            $display("CHECKS FAILED");
            $finish;
        end
    end

    // Random gap length: mostly short, sometimes long.
    function automatic int pick_gap();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 50)
            return 0;
        else if (roll < 90)
            return $urandom_range(1, 3);
        else
            return $urandom_range(10, 40);
    endfunction

    // Adds one pair to the sums and, on the last pair, predicts the result.
    function automatic void predict_pair(logic signed [csim_pkg::ElemW-1:0] a,
                                         logic signed [csim_pkg::ElemW-1:0] b,
                                         logic last);
        logic signed [2*csim_pkg::ElemW-1:0] prod_ab;
        logic signed [2*csim_pkg::ElemW-1:0] prod_aa;
        logic signed [2*csim_pkg::ElemW-1:0] prod_bb;
        logic                                neg;
        logic [csim_pkg::AccW-1:0]           mag;
        logic [127:0]                        energy_prod;
        logic [127:0]                        dot_sq;
        logic [16:0]                         m;
        logic [16:0]                         trial;
        sim_result_t                         res;
        prod_ab = a * b;
        prod_aa = a * a;
        prod_bb = b * b;
        dot_acc      = dot_acc + {{(csim_pkg::AccW-2*csim_pkg::ElemW){prod_ab[2*csim_pkg::ElemW-1]}},
                                  prod_ab};
        energy_acc_a = energy_acc_a + {{(csim_pkg::AccW-2*csim_pkg::ElemW){1'b0}}, prod_aa};
        energy_acc_b = energy_acc_b + {{(csim_pkg::AccW-2*csim_pkg::ElemW){1'b0}}, prod_bb};
        if (!last)
            return;
        if (energy_acc_a == '0 || energy_acc_b == '0)
        begin
            res.similarity = '0;
            res.zero_norm  = 1'b1;
        end
        else
        begin
            neg = dot_acc[csim_pkg::AccW-1];
            mag = neg ? -dot_acc : dot_acc;
            energy_prod = 128'(energy_acc_a) * 128'(energy_acc_b);
            dot_sq = (128'(mag) * 128'(mag)) << 30;
            m = '0;
            // Bitwise search for the largest m with m^2 * Ea * Eb <= dot^2 * 2^30.
            for (int bit_pos = 15; bit_pos >= 0; bit_pos--)
            begin
                trial = m | (17'd1 << bit_pos);
                if (trial <= 17'd32768 &&
                    energy_prod * 128'(trial) * 128'(trial) <= dot_sq)
                    m = trial;
            end
            if (neg)
                res.similarity = 16'(17'h10000 - m);
            else
                res.similarity = (m > 17'd32767) ? 16'sd32767 : m[15:0];
            res.zero_norm = 1'b0;
        end
        pending_results.push_back(res);
        dot_acc      = '0;
        energy_acc_a = '0;
        energy_acc_b = '0;
    endfunction

    // Sends one element pair and waits for its transfer.
    task automatic send_pair(logic signed [csim_pkg::ElemW-1:0] a,
                             logic signed [csim_pkg::ElemW-1:0] b, logic last);
        int gap;
        @(negedge clk);
        in_ch.valid   <= 1'b1;
        in_ch.elem_a  <= a;
        in_ch.elem_b  <= b;
        in_ch.is_last <= last;
        do
            @(posedge clk);
        while (!in_ch.ready);
        predict_pair(a, b, last);
        pairs_sent++;
        if (last)
            vectors_sent++;
        gap = idle_enable ? pick_gap() : 0;
        if (gap > 0)
        begin
            @(negedge clk);
            in_ch.valid <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
    endtask

    // Result side back-pressure.
    initial
    begin
        int stall_left;
        out_ch.ready = 1'b0;
        stall_left = 0;
        forever
        begin
            @(negedge clk);
            if (!stall_enable)
                out_ch.ready <= 1'b1;
            else if (stall_left > 0)
            begin
                out_ch.ready <= 1'b0;
                stall_left--;
            end
            else
            begin
                stall_left = pick_gap();
                out_ch.ready <= (stall_left == 0);
            end
        end
    end

    // Compares each result transfer with the oldest prediction.
    always @(posedge clk)
    begin
        sim_result_t want;
        if (rst_n && out_ch.valid && out_ch.ready)
        begin
            results_seen++;
            if (pending_results.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("Unexpected result: similarity=%0d zero_norm=%0b",
                             out_ch.similarity, out_ch.zero_norm);
            end
            else
            begin
                want = pending_results.pop_front();
                if (out_ch.similarity !== want.similarity ||
                    out_ch.zero_norm !== want.zero_norm)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("Result %0d: similarity exp %0d got %0d, %s %0b got %0b",
                                 results_seen, want.similarity, out_ch.similarity,
                                 "zero_norm exp", want.zero_norm, out_ch.zero_norm);
                end
                if (out_ch.zero_norm)
                    zero_norm_seen++;
            end
        end
    end

    // Full-scale elements: saturation at +1.0 and the most negative outputs.
    task automatic test_extremes();
        send_pair(-16'sd32768, -16'sd32768, 1'b1);
        send_pair(-16'sd32768, 16'sd32767, 1'b1);
        send_pair(16'sd32767, 16'sd32767, 1'b1);
        send_pair(16'sd32767, -16'sd32768, 1'b1);
        send_pair(16'sd32767, 16'sd32767, 1'b0);
        send_pair(-16'sd32768, -16'sd32768, 1'b1);
        send_pair(-16'sd1, 16'sd1, 1'b1);
    endtask

    // Either norm zero forces a zero similarity with the flag raised.
    task automatic test_zero_norm();
        send_pair(16'sd0, 16'sd5, 1'b1);
        send_pair(16'sd7, 16'sd0, 1'b1);
        send_pair(16'sd0, 16'sd0, 1'b1);
        send_pair(16'sd0, -16'sd32768, 1'b0);
        send_pair(16'sd0, 16'sd12, 1'b1);
    endtask

    // Multi-pair vectors: orthogonal, mixed sign and ordinary values.
    task automatic test_short_vectors();
        send_pair(16'sd1, 16'sd0, 1'b0);
        send_pair(16'sd0, 16'sd1, 1'b1);
        send_pair(16'sd3, 16'sd4, 1'b0);
        send_pair(16'sd4, -16'sd3, 1'b0);
        send_pair(16'sd100, -16'sd100, 1'b0);
        send_pair(-16'sd5, 16'sd6, 1'b1);
        send_pair(16'sh5555, 16'shAAAA, 1'b0);
        send_pair(16'shAAAA, 16'sh5555, 1'b1);
    endtask

    // Long vectors of full-scale elements drive the sums far above one pair.
    task automatic test_long_vectors();
        for (int i = 0; i < LongLength; i++)
            send_pair(-16'sd32768, -16'sd32768, i == LongLength - 1);
        for (int i = 0; i < LongLength; i++)
            send_pair(16'sh8000, 16'sh7FFF, i == LongLength - 1);
    endtask

    // Random vectors of mostly short length with varied element shapes.
    task automatic test_random();
        int unsigned count;
        int          len;
        int          shape;
        logic signed [csim_pkg::ElemW-1:0] a;
        logic signed [csim_pkg::ElemW-1:0] b;
        count = 0;
        while (count < RandomItems)
        begin
            // Alternate stretches with and without idling on both sides.
            if ($urandom_range(0, 9) == 0)
            begin
                idle_enable  = $urandom_range(0, 1);
                stall_enable = $urandom_range(0, 1);
            end
            len = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 40)
                                              : $urandom_range(1, 8);
            shape = $urandom_range(0, 5);
            for (int i = 0; i < len; i++)
            begin
                a = csim_pkg::ElemW'($urandom);
                b = csim_pkg::ElemW'($urandom);
                case (shape)
                    1: b = a;
                    2: b = -a;
                    3:
                    begin
                        a = $urandom_range(0, 1) ? -16'sd32768 : 16'sd32767;
                        b = $urandom_range(0, 1) ? -16'sd32768 : 16'sd32767;
                    end
                    4:
                    begin
                        a = $signed(16'($urandom_range(0, 6))) - 16'sd3;
                        b = $signed(16'($urandom_range(0, 6))) - 16'sd3;
                    end
                    5: a = ($urandom_range(0, 1) == 0) ? 16'sd0 : a;
                    default: ;
                endcase
                send_pair(a, b, i == len - 1);
                count++;
            end
        end
    endtask

    // Test sequence.
    initial
    begin
        int unsigned waited;
        rst_n            = 1'b0;
        in_ch.valid      = 1'b0;
        in_ch.elem_a     = '0;
        in_ch.elem_b     = '0;
        in_ch.is_last    = 1'b0;
        dot_acc          = '0;
        energy_acc_a     = '0;
        energy_acc_b     = '0;
        mismatches       = 0;
        results_seen     = 0;
        vectors_sent     = 0;
        pairs_sent       = 0;
        zero_norm_seen   = 0;
        cycle_count      = 0;
        idle_enable      = 1'b1;
        stall_enable     = 1'b1;
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_extremes();
        test_zero_norm();
        test_short_vectors();
        idle_enable  = 1'b0;
        stall_enable = 1'b0;
        test_long_vectors();
        idle_enable  = 1'b1;
        stall_enable = 1'b1;
        test_random();

        @(negedge clk);
        in_ch.valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        waited = 0;
        while (waited < DrainCycles)
        begin
            @(posedge clk);
            waited++;
        end

        $display("Sent %0d element pairs in %0d vectors, checked %0d results",
                 pairs_sent, vectors_sent, results_seen);
        $display("Zero-norm results: %0d, mismatches: %0d", zero_norm_seen, mismatches);
        if (mismatches == 0 && pending_results.size() == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
